[hdl/ntps_pkg.sv]
package ntps_pkg;

  localparam int CoordW = 19;
  localparam int DistW  = 34;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DistW-1:0] dist_t;

  localparam logic [2:0] REG_SEARCH_LEFT   = 3'd0;
  localparam logic [2:0] REG_SEARCH_TOP    = 3'd1;
  localparam logic [2:0] REG_SEARCH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SEARCH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CURSOR_X      = 3'd4;
  localparam logic [2:0] REG_CURSOR_Y      = 3'd5;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic               last;
  } ntps_rect_t;

  typedef struct packed {
    coord_t sl;
    coord_t st;
    coord_t sr;
    coord_t sb;
    coord_t cx;
    coord_t cy;
    logic   area_ok;
  } ntps_cfg_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        keep;
    dist_t       sq_dist;
    logic [15:0] px;
    logic [15:0] py;
  } ntps_cand_t;

endpackage

[hdl/ntps_intf.sv]
interface ntps_rect_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [14:0]        rect_w;
  logic [14:0]        rect_h;
  logic               last;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, last, input ready);
  modport sink (input valid, rect_x, rect_y, rect_w, rect_h, last, output ready);
endinterface

interface ntps_point_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;

  modport source (output valid, found, point_x, point_y, input ready);
  modport sink (input valid, found, point_x, point_y, output ready);
endinterface

interface ntps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/ntps_geom.sv]
module ntps_geom
  import ntps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  ntps_rect_t in_rect,
  input  ntps_cfg_t  cfg,
  output ntps_cand_t cand
);

  // stage 1: shrunk candidate edges
  logic   v1, last1;
  coord_t s1_x, s1_y, s1_w, s1_h, s1_r, s1_b;
  // stage 2: overlap and clip
  logic   v2, last2, ov2;
  coord_t s2_l, s2_t, s2_r, s2_b, s2_w, s2_h;
  // stage 3: cut test and inner clip bounds
  logic   v3, last3, keep3, inner3;
  coord_t s3_lox, s3_hix, s3_loy, s3_hiy;
  // stage 4: clamped point
  logic   v4, last4, keep4;
  coord_t s4_px, s4_py;
  // stage 5: offsets
  logic   v5, last5, keep5;
  coord_t s5_dx, s5_dy;
  logic [15:0] s5_px, s5_py;
  // stage 6: squares
  logic   v6, last6, keep6;
  dist_t  s6_qx, s6_qy;
  logic [15:0] s6_px, s6_py;

  coord_t xe, ye, we, he;
  logic   ov;
  coord_t l, t, r, b, iw, ih;
  logic   cut;
  coord_t px, py;
  logic signed [2*CoordW-1:0] sqx, sqy;

  always_comb begin
    xe = coord_t'(in_rect.rect_x);
    ye = coord_t'(in_rect.rect_y);
    we = coord_t'({1'b0, in_rect.rect_w});
    he = coord_t'({1'b0, in_rect.rect_h});
  end

  always_comb begin
    ov = (s1_w > 0) && (s1_h > 0) && cfg.area_ok &&
         (s1_x < cfg.sr) && (cfg.sl < s1_r) && (s1_y < cfg.sb) && (cfg.st < s1_b);
    l  = (s1_x > cfg.sl) ? s1_x : cfg.sl;
    t  = (s1_y > cfg.st) ? s1_y : cfg.st;
    r  = (s1_r < cfg.sr) ? s1_r : cfg.sr;
    b  = (s1_b < cfg.sb) ? s1_b : cfg.sb;
  end

  always_comb begin
    iw  = s2_r - s2_l;
    ih  = s2_b - s2_t;
    cut = ((s2_w != iw) && (iw < coord_t'(5))) || ((s2_h != ih) && (ih < coord_t'(5)));
  end

  always_comb begin
    px = '0;
    py = '0;
    if (inner3) begin
      px = (cfg.cx < s3_hix) ? cfg.cx : s3_hix;
      px = (px > s3_lox) ? px : s3_lox;
      py = (cfg.cy < s3_hiy) ? cfg.cy : s3_hiy;
      py = (py > s3_loy) ? py : s3_loy;
    end
  end

  assign sqx = s5_dx * s5_dx;
  assign sqy = s5_dy * s5_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      cand.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      cand.valid   <= v6;
      cand.last    <= last6;
      cand.keep    <= keep6;
      cand.sq_dist <= s6_qx + s6_qy;
      cand.px      <= s6_px;
      cand.py      <= s6_py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last1 <= in_rect.last;
      s1_x  <= xe + coord_t'(2);
      s1_y  <= ye + coord_t'(2);
      s1_w  <= we - coord_t'(4);
      s1_h  <= he - coord_t'(4);
      s1_r  <= xe + we - coord_t'(2);
      s1_b  <= ye + he - coord_t'(2);

      last2 <= last1;
      ov2   <= ov;
      s2_l  <= l;
      s2_t  <= t;
      s2_r  <= r;
      s2_b  <= b;
      s2_w  <= s1_w;
      s2_h  <= s1_h;

      last3  <= last2;
      keep3  <= ov2 && !cut;
      inner3 <= (iw > coord_t'(2)) && (ih > coord_t'(2));
      s3_lox <= s2_l + coord_t'(1);
      s3_hix <= s2_r - coord_t'(1);
      s3_loy <= s2_t + coord_t'(1);
      s3_hiy <= s2_b - coord_t'(1);

      last4 <= last3;
      keep4 <= keep3;
      s4_px <= px;
      s4_py <= py;

      last5 <= last4;
      keep5 <= keep4;
      s5_dx <= s4_px - cfg.cx;
      s5_dy <= s4_py - cfg.cy;
      s5_px <= s4_px[15:0];
      s5_py <= s4_py[15:0];

      last6 <= last5;
      keep6 <= keep5;
      s6_qx <= sqx[DistW-1:0];
      s6_qy <= sqy[DistW-1:0];
      s6_px <= s5_px;
      s6_py <= s5_py;
    end
  end

endmodule

[hdl/nearest_target_point_select.sv]
// Nearest target point selector. Candidate rectangles stream in on rect, one beat per
// cycle unless halted, with last set on the final rectangle of a list. The user must write
// the config registers (search rectangle and cursor) on cfg only while the block is idle;
// the block itself does not enforce it. Each rectangle goes through a pipeline (edge adds,
// clip, cut test, clamp, offset, square, sum, running-minimum compare), and a list's
// single result is registered on point after its last beat. The whole pipeline halts only
// while a finished result sits in the output register and point.ready is low.
module nearest_target_point_select
  import ntps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  ntps_rect_if.sink           rect,
  ntps_point_if.source        point,
  ntps_cfg_if.sink            cfg
);

  logic signed [15:0] search_left, search_top, cursor_x, cursor_y;
  logic [14:0]        search_width, search_height;
  ntps_cfg_t          cfg_q;

  logic       en;
  ntps_rect_t in_rect;
  ntps_cand_t cand;

  logic        have_best;
  dist_t       best_dist;
  logic [15:0] best_x, best_y;
  logic        upd, hb_next;
  logic [15:0] bx_next, by_next;

  assign cfg.ready = 1'b1;
  assign en         = !point.valid || point.ready;
  assign rect.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_left   <= '0;
      search_top    <= '0;
      search_width  <= '0;
      search_height <= '0;
      cursor_x      <= '0;
      cursor_y      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SEARCH_LEFT:   search_left   <= cfg.data;
        REG_SEARCH_TOP:    search_top    <= cfg.data;
        REG_SEARCH_WIDTH:  search_width  <= cfg.data[14:0];
        REG_SEARCH_HEIGHT: search_height <= cfg.data[14:0];
        REG_CURSOR_X:      cursor_x      <= cfg.data;
        REG_CURSOR_Y:      cursor_y      <= cfg.data;
        default: ;
      endcase
    end
  end

  // derived search bounds, registered from the config registers
  always_ff @(posedge clk) begin
    cfg_q.sl      <= coord_t'(search_left);
    cfg_q.st      <= coord_t'(search_top);
    cfg_q.sr      <= coord_t'(search_left) + coord_t'({1'b0, search_width});
    cfg_q.sb      <= coord_t'(search_top) + coord_t'({1'b0, search_height});
    cfg_q.cx      <= coord_t'(cursor_x);
    cfg_q.cy      <= coord_t'(cursor_y);
    cfg_q.area_ok <= (search_width != '0) && (search_height != '0);
  end

  always_comb begin
    in_rect.rect_x = rect.rect_x;
    in_rect.rect_y = rect.rect_y;
    in_rect.rect_w = rect.rect_w;
    in_rect.rect_h = rect.rect_h;
    in_rect.last   = rect.last;
  end

  ntps_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rect.valid),
    .in_rect  (in_rect),
    .cfg      (cfg_q),
    .cand     (cand)
  );

  // running minimum, first strictly smaller wins
  always_comb begin
    upd     = cand.valid && cand.keep && (!have_best || (best_dist > cand.sq_dist));
    hb_next = have_best || upd;
    bx_next = upd ? cand.px : best_x;
    by_next = upd ? cand.py : best_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_dist <= '0;
    end else if (en && cand.valid) begin
      if (cand.last) begin
        have_best <= 1'b0;
        best_dist <= '0;
      end else if (upd) begin
        have_best <= 1'b1;
        best_dist <= cand.sq_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && upd) begin
      best_x <= cand.px;
      best_y <= cand.py;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (en) begin
      point.valid <= cand.valid && cand.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && cand.valid && cand.last) begin
      point.found   <= hb_next;
      point.point_x <= hb_next ? bx_next : cursor_x;
      point.point_y <= hb_next ? by_next : cursor_y;
    end
  end

endmodule

[sim/ntps_checker.sv]
module ntps_checker
  import ntps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ntps_rect_if  rect,
  ntps_point_if point,
  ntps_cfg_if   cfg,
  output int    errors,
  output int    pending
);

  typedef struct {
    logic        found;
    logic [15:0] px;
    logic [15:0] py;
  } point_beat_t;

  logic signed [15:0] search_left, search_top, cursor_x, cursor_y;
  logic [14:0]        search_width, search_height;

  logic               have_best;
  longint             best_dist;
  logic [15:0]        best_x, best_y;

  point_beat_t        expected_points[$];

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  task automatic fold_rect(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [14:0] w, input logic [14:0] h, input logic is_last);
    longint nx, ny, nw, nh, sl, st, sw, sh, cx, cy;
    longint l, t, iw, ih, cl, ct, cw, ch, px, py, d;
    bit cut;
    point_beat_t res;
    nx = longint'(x) + 2;
    ny = longint'(y) + 2;
    nw = longint'(w) - 4;
    nh = longint'(h) - 4;
    sl = longint'(search_left);
    st = longint'(search_top);
    sw = longint'(search_width);
    sh = longint'(search_height);
    cx = longint'(cursor_x);
    cy = longint'(cursor_y);
    if (nw > 0 && nh > 0 && sw > 0 && sh > 0 &&
        nx < sl + sw && sl < nx + nw && ny < st + sh && st < ny + nh) begin
      l  = lmax(nx, sl);
      t  = lmax(ny, st);
      iw = lmin(nx + nw, sl + sw) - l;
      ih = lmin(ny + nh, st + sh) - t;
      cut = (nw != iw && iw < 5) || (nh != ih && ih < 5);
      if (!cut) begin
        cl = l + 1;
        ct = t + 1;
        cw = iw - 2;
        ch = ih - 2;
        px = 0;
        py = 0;
        if (cw > 0 && ch > 0) begin
          px = lmax(cl, lmin(cl + cw, cx));
          py = lmax(ct, lmin(ct + ch, cy));
        end
        // exact distance, the stored point wraps to 16 bits
        d = (px - cx) * (px - cx) + (py - cy) * (py - cy);
        if (!have_best || best_dist > d) begin
          have_best = 1'b1;
          best_dist = d;
          best_x    = px[15:0];
          best_y    = py[15:0];
        end
      end
    end
    if (is_last) begin
      res.found = have_best;
      res.px    = have_best ? best_x : cursor_x;
      res.py    = have_best ? best_y : cursor_y;
      expected_points.push_back(res);
      have_best = 1'b0;
      best_dist = 0;
    end
  endtask

  always @(posedge clk) begin
    point_beat_t want;
    if (rst) begin
      search_left   = '0;
      search_top    = '0;
      search_width  = '0;
      search_height = '0;
      cursor_x      = '0;
      cursor_y      = '0;
      have_best     = 1'b0;
      best_dist     = 0;
      best_x        = '0;
      best_y        = '0;
      errors        = 0;
      expected_points.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SEARCH_LEFT:   search_left   = cfg.data;
          REG_SEARCH_TOP:    search_top    = cfg.data;
          REG_SEARCH_WIDTH:  search_width  = cfg.data[14:0];
          REG_SEARCH_HEIGHT: search_height = cfg.data[14:0];
          REG_CURSOR_X:      cursor_x      = cfg.data;
          REG_CURSOR_Y:      cursor_y      = cfg.data;
          default: ;
        endcase
      end
      if (rect.valid && rect.ready) begin
        fold_rect(rect.rect_x, rect.rect_y, rect.rect_w, rect.rect_h, rect.last);
      end
      if (point.valid && point.ready) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected point beat, expected none, got found=%0b x=%0d y=%0d",
                   $time, point.found, $signed(point.point_x), $signed(point.point_y));
        end else begin
          want = expected_points.pop_front();
          if (point.found !== want.found || point.point_x !== want.px ||
              point.point_y !== want.py) begin
            errors++;
            $display("%0t: point mismatch, expected found=%0b x=%0d y=%0d, got found=%0b x=%0d y=%0d",
                     $time, want.found, $signed(want.px), $signed(want.py),
                     point.found, $signed(point.point_x), $signed(point.point_y));
          end
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

[sim/nearest_target_point_select_tb.sv]
module nearest_target_point_select_tb;
  import ntps_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam logic [2:0] RegSpare0 = 3'd6;
  localparam logic [2:0] RegSpare1 = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   awaiting;
  int   cycle_count = 0;
  int   src_calm = 0;
  int   snk_calm = 0;
  int   search_l, search_t, search_w, search_h;
  int   stall;
  ntps_rect_t prev_rect = '0;

  ntps_rect_if  rect ();
  ntps_point_if point ();
  ntps_cfg_if   cfg ();

  nearest_target_point_select dut (
    .clk   (clk),
    .rst   (rst),
    .rect  (rect),
    .point (point),
    .cfg   (cfg)
  );

  ntps_checker point_check (
    .clk     (clk),
    .rst     (rst),
    .rect    (rect),
    .point   (point),
    .cfg     (cfg),
    .errors  (mismatches),
    .pending (awaiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic int pick_extreme(int lo, int hi);
    case ($urandom_range(0, 2))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic ntps_rect_t rect_of(int x, int y, int w, int h, bit is_last);
    ntps_rect_t r;
    r.rect_x = x[15:0];
    r.rect_y = y[15:0];
    r.rect_w = w[14:0];
    r.rect_h = h[14:0];
    r.last   = is_last;
    return r;
  endfunction

  function automatic ntps_rect_t make_rect(bit is_last);
    ntps_rect_t r;
    int x, y, w, h, pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // repeat of the previous beat, makes ties
      r = prev_rect;
      r.last = is_last;
      return r;
    end else if (pick < 65) begin
      x = search_l - 30 + int'($urandom_range(0, search_w + 40));
      y = search_t - 30 + int'($urandom_range(0, search_h + 40));
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, search_w + 40) : $urandom_range(0, 60);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, search_h + 40) : $urandom_range(0, 60);
    end else if (pick < 80) begin
      // straddling an edge, small clips
      x = $urandom_range(0, 1) ? search_l - int'($urandom_range(0, 12))
                               : search_l + search_w - int'($urandom_range(0, 12));
      y = $urandom_range(0, 1) ? search_t - int'($urandom_range(0, 12))
                               : search_t + search_h - int'($urandom_range(0, 12));
      w = $urandom_range(4, 24);
      h = $urandom_range(4, 24);
    end else begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end
    return rect_of(x, y, w, h, is_last);
  endfunction

  task automatic send_rect(input ntps_rect_t r);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      rect.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect.valid  <= 1'b1;
    rect.rect_x <= r.rect_x;
    rect.rect_y <= r.rect_y;
    rect.rect_w <= r.rect_w;
    rect.rect_h <= r.rect_h;
    rect.last   <= r.last;
    @(posedge clk);
    while (!rect.ready) @(posedge clk);
    prev_rect = r;
  endtask

  task automatic write_config(input int l, input int t, input int w, input int h,
                              input int x, input int y, input bit spare);
    logic [2:0]  idx [8];
    logic [15:0] vals [8];
    int n;
    idx[0] = REG_SEARCH_LEFT;   vals[0] = l[15:0];
    idx[1] = REG_SEARCH_TOP;    vals[1] = t[15:0];
    idx[2] = REG_SEARCH_WIDTH;  vals[2] = {1'($urandom_range(0, 1)), w[14:0]};
    idx[3] = REG_SEARCH_HEIGHT; vals[3] = {1'($urandom_range(0, 1)), h[14:0]};
    idx[4] = REG_CURSOR_X;      vals[4] = x[15:0];
    idx[5] = REG_CURSOR_Y;      vals[5] = y[15:0];
    idx[6] = RegSpare0;         vals[6] = 16'($urandom);
    idx[7] = RegSpare1;         vals[7] = 16'($urandom);
    n = spare ? 8 : 6;
    for (int i = 0; i < n; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data  <= vals[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    search_l = l;
    search_t = t;
    search_w = w & 32767;
    search_h = h & 32767;
  endtask

  task automatic drain();
    rect.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_setup(input int mode);
    int l, t, w, h, x, y;
    case (mode)
      0: begin
        l = int'($urandom_range(0, 2000)) - 1000;
        t = int'($urandom_range(0, 2000)) - 1000;
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
        x = l - 200 + int'($urandom_range(0, w + 400));
        y = t - 200 + int'($urandom_range(0, h + 400));
      end
      1: begin
        l = pick_extreme(-32768, 32767);
        t = pick_extreme(-32768, 32767);
        w = pick_extreme(0, 32767);
        h = pick_extreme(0, 32767);
        x = pick_extreme(-32768, 32767);
        y = pick_extreme(-32768, 32767);
      end
      default: begin
        l = int'($urandom_range(0, 65535)) - 32768;
        t = int'($urandom_range(0, 65535)) - 32768;
        w = $urandom_range(0, 32767);
        h = $urandom_range(0, 32767);
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    write_config(l, t, w, h, x, y, $urandom_range(0, 3) == 0);
  endtask

  task automatic send_lists(input int count);
    int len, sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_rect(make_rect(i == len - 1));
      sent += len;
    end
  endtask

  initial begin
    point.ready = 1'b0;
    forever begin
      stall = draw_gap(snk_calm);
      if (stall > 0) begin
        point.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      point.ready <= 1'b1;
      @(posedge clk);
      while (!point.valid) @(posedge clk);
    end
  end

  initial begin
    rst         = 1'b1;
    rect.valid  = 1'b0;
    rect.rect_x = '0;
    rect.rect_y = '0;
    rect.rect_w = '0;
    rect.rect_h = '0;
    rect.last   = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // search area x in [-100, 300), y in [-50, 250)
    write_config(-100, -50, 400, 300, 37, -12, 1'b1);
    send_rect(rect_of(0, -40, 100, 100, 1'b1));
    // equal distances, first one stays
    send_rect(rect_of(200, 150, 40, 40, 1'b0));
    send_rect(rect_of(60, -20, 20, 20, 1'b0));
    send_rect(rect_of(-10, -20, 24, 20, 1'b0));
    send_rect(rect_of(60, -20, 20, 20, 1'b1));
    send_rect(rect_of(10, 10, 4, 50, 1'b1));
    send_rect(rect_of(-110, 0, 16, 40, 1'b1));
    // clip collapses after the inner shrink
    send_rect(rect_of(50, 50, 6, 6, 1'b1));
    send_rect(rect_of(-32768, -32768, 32767, 32767, 1'b0));
    send_rect(rect_of(32767, 32767, 0, 0, 1'b1));
    send_rect(rect_of(298, 0, 40, 40, 1'b0));
    send_rect(rect_of(-138, 0, 40, 40, 1'b1));
    send_rect(rect_of(-32768, 32767, 32767, 1, 1'b1));
    drain();

    // empty search area
    write_config(-100, -50, 0, 300, 37, -12, 1'b0);
    send_rect(rect_of(0, 0, 100, 100, 1'b0));
    send_rect(rect_of(-32768, -32768, 32767, 32767, 1'b1));
    drain();

    // clamped point past 16 bits
    write_config(32767, 0, 32767, 100, 32767, 20, 1'b0);
    send_rect(rect_of(32760, 10, 20, 20, 1'b1));
    send_rect(rect_of(32767, 10, 32767, 20, 1'b1));
    drain();

    write_config(-32768, -32768, 32767, 32767, -32768, -32768, 1'b0);
    send_rect(rect_of(0, 0, 100, 100, 1'b0));
    send_rect(rect_of(-32768, -32768, 32767, 32767, 1'b1));
    drain();

    for (int p = 0; p < 12; p++) begin
      random_setup(p % 3);
      send_lists(150);
      drain();
    end

    if (mismatches == 0 && awaiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
